### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### design/dcrq_pkg.sv
// ----------------------------------------------------------------------------
// dcrq_pkg
// shared types and constants of the distinct count range query block
// ----------------------------------------------------------------------------
`default_nettype none

package dcrq_pkg;

    // request and result field widths
    localparam int VAL_W       = 10;
    localparam int LEFT_W      = 11;
    localparam int CNT_W       = 11;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_PAD_W    = IN_TDATA_W - VAL_W - LEFT_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CNT_W - STAT_W;
    localparam int BIT_CNT_W   = 4;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_LEFT = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_LP_RD,
        S_LP_CHK,
        S_RM_WAIT,
        S_ADD_WAIT,
        S_Q1_WAIT,
        S_Q2_WAIT,
        S_DONE
    } state_t;

    // command to the tree walk unit
    typedef struct packed {
        logic start;
        logic add_mode;   // 1: point update walk, 0: prefix sum walk
        logic negate;     // update by -1 / subtract the prefix
        logic clear_acc;  // zero the accumulator at start
    } walk_ctl_t;

endpackage

`default_nettype wire

### design/dcrq_ram.sv
// ----------------------------------------------------------------------------
// dcrq_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dcrq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/dcrq_walk.sv
// ----------------------------------------------------------------------------
// dcrq_walk
// shared fenwick walk unit: one tree node per cycle, update or prefix sum
// ----------------------------------------------------------------------------
`default_nettype none

module dcrq_walk
    import dcrq_pkg::*;
#(
    parameter int MAX_LENGTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire walk_ctl_t                           ctl,
    input  wire logic [$clog2(MAX_LENGTH+1):0]       at,
    output logic                                     busy,
    output logic [CNT_W-1:0]                         acc,
    output logic [$clog2(MAX_LENGTH)-1:0]            tree_raddr,
    input  wire logic [$clog2(MAX_LENGTH+1)-1:0]     tree_rdata,
    output logic                                     tree_we,
    output logic [$clog2(MAX_LENGTH)-1:0]            tree_waddr,
    output logic [$clog2(MAX_LENGTH+1)-1:0]          tree_wdata
);

    localparam int TW = $clog2(MAX_LENGTH + 1);
    localparam int IW = TW + 1;
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int DW = (TW > CNT_W) ? TW : CNT_W;

    logic          act_reg,  act_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] at_reg,   at_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic          add_reg,  add_next;
    logic          neg_reg,  neg_next;
    logic [CNT_W-1:0] acc_reg, acc_next;

    logic          in_range;
    logic          issue;
    logic [IW-1:0] low_bit;
    logic [DW-1:0] data_wide;

    // node index step: up the tree for updates, down for prefix sums
    assign low_bit   = at_reg & (~at_reg + 1'b1);
    assign in_range  = (at_reg != '0) && (at_reg <= IW'(MAX_LENGTH));
    assign issue     = act_reg && in_range;
    assign data_wide = DW'(tree_rdata);

    assign tree_raddr = AW'(at_reg - 1'b1);
    assign tree_we    = pend_reg && add_reg;
    assign tree_waddr = paddr_reg;
    assign tree_wdata = tree_rdata + (neg_reg ? {TW{1'b1}} : TW'(1));

    assign busy = act_reg || pend_reg;
    assign acc  = acc_reg;

    always_comb
    begin
        act_next   = act_reg;
        at_next    = at_reg;
        add_next   = add_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        pend_next  = issue;
        paddr_next = tree_raddr;

        if (ctl.start)
        begin
            act_next = 1'b1;
            at_next  = at;
            add_next = ctl.add_mode;
            neg_next = ctl.negate;
        end
        else if (issue)
        begin
            at_next = add_reg ? (at_reg + low_bit) : (at_reg & (at_reg - 1'b1));
        end
        else
        begin
            act_next = 1'b0;
        end

        // prefix walk folds each node read into the running sum
        if (pend_reg && !add_reg)
        begin
            acc_next = neg_reg ? (acc_reg - data_wide[CNT_W-1:0])
                               : (acc_reg + data_wide[CNT_W-1:0]);
        end

        if (ctl.start && ctl.clear_acc)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        at_reg    <= at_next;
        add_reg   <= add_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        paddr_reg <= paddr_next;
    end

endmodule

`default_nettype wire

### design/distinct_count_range_query.sv
// an append folds the value when VALUE_COUNT < 1024, reads its last position, then runs a
// removal walk if the value was seen and an add walk; a query runs two prefix walks
// throughput: one request at a time; the two fenwick walks on the single tree port set the time
// reset: rst_n low clears control state at once; afterwards both tables are zeroed in a pass over
// max(MAX_LENGTH, VALUE_COUNT) addresses (1024 by default) during which no request is taken
// a finished result waits in the output register while the next request is accepted
// ----------------------------------------------------------------------------
// distinct_count_range_query
// distinct values in left..length of an appended stream, fenwick tree of
// latest occurrences plus a table of last positions per value
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module distinct_count_range_query
    import dcrq_pkg::*;
#(
    parameter int MAX_LENGTH  = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value [9:0], left [20:10], zero pad
    input  wire logic                   s_tuser,   // req_type: 0 append, 1 query
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // distinct_count [10:0], status [12:11], pad
);

    // widths that follow the table sizes
    localparam int TW     = $clog2(MAX_LENGTH + 1);   // position / tree entry
    localparam int IW     = TW + 1;                   // walk index, may pass MAX_LENGTH
    localparam int AW     = $clog2(MAX_LENGTH);       // tree address
    localparam int VW     = $clog2(VALUE_COUNT);      // last position table address
    localparam int LW     = (TW > LEFT_W) ? TW : LEFT_W;
    localparam int CLR_N  = (MAX_LENGTH > VALUE_COUNT) ? MAX_LENGTH : VALUE_COUNT;
    localparam int CLW    = $clog2(CLR_N);
    // values beyond the table are folded by a reciprocal multiply: quotient, then remainder
    localparam bit REDUCE = (VALUE_COUNT < (1 << VAL_W));
    localparam int VC_RED = REDUCE ? VALUE_COUNT : 1;
    localparam int RCP_SH = 2 * VAL_W;
    localparam int RCP_INT = ((1 << RCP_SH) + VC_RED - 1) / VC_RED;
    localparam logic [RCP_SH:0] RCP_M = (RCP_SH + 1)'(RCP_INT);
    localparam logic [VAL_W:0] VC_N = (VAL_W + 1)'(VC_RED);

    state_t state_reg, state_next;

    logic [CLW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [TW-1:0]        len_reg,     len_next;
    logic [VAL_W-1:0]     val_reg,     val_next;
    logic [VAL_W:0]       rem_reg,     rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [LEFT_W-1:0]    left_reg,    left_next;
    logic [CNT_W-1:0]     res_cnt_reg, res_cnt_next;
    status_t              res_st_reg,  res_st_next;
    logic                 ov_reg,      ov_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    status_t              out_st_reg,  out_st_next;

    // request fields
    logic              in_req;
    logic [VAL_W-1:0]  in_value;
    logic [LEFT_W-1:0] in_left;
    logic              accept;

    assign in_req   = s_tuser;
    assign in_value = s_tdata[VAL_W-1:0];
    assign in_left  = s_tdata[VAL_W +: LEFT_W];
    assign accept   = s_tvalid && s_tready;

    // derived values
    logic [TW-1:0]    pos;
    logic             is_full;
    logic             bad_left;
    logic [LW-1:0]    left_m1;
    logic [VW-1:0]    vidx;
    logic [VAL_W+RCP_SH:0] mod_prod;
    logic [2*VAL_W+1:0]    mod_back;
    logic [VAL_W:0]   mod_quot;
    logic [VAL_W:0]   mod_rem;
    logic             clr_last;
    logic             clr_tree_en;
    logic             clr_lp_en;

    assign pos       = len_reg + 1'b1;
    assign is_full   = (len_reg == TW'(MAX_LENGTH));
    assign bad_left  = (in_left == '0) || (LW'(in_left) > LW'(len_reg));
    assign left_m1   = LW'(left_reg) - 1'b1;
    assign vidx      = REDUCE ? VW'(rem_reg) : VW'(val_reg);
    assign mod_prod  = {{(RCP_SH + 1){1'b0}}, val_reg} * {{VAL_W{1'b0}}, RCP_M};
    assign mod_quot  = mod_prod[VAL_W+RCP_SH:RCP_SH];
    assign mod_back  = {{(VAL_W + 1){1'b0}}, rem_reg} * {{(VAL_W + 1){1'b0}}, VC_N};
    assign mod_rem   = {1'b0, val_reg} - mod_back[VAL_W:0];
    assign clr_last  = (clr_cnt_reg == CLW'(CLR_N - 1));
    assign clr_tree_en = ({1'b0, clr_cnt_reg} < (CLW + 1)'(MAX_LENGTH));
    assign clr_lp_en   = ({1'b0, clr_cnt_reg} < (CLW + 1)'(VALUE_COUNT));

    // walk unit and tables
    walk_ctl_t         walk_ctl;
    logic [IW-1:0]     walk_at;
    logic              walk_busy;
    logic [CNT_W-1:0]  walk_acc;
    logic [AW-1:0]     tree_raddr;
    logic [TW-1:0]     tree_rdata;
    logic              walk_tree_we;
    logic [AW-1:0]     walk_tree_waddr;
    logic [TW-1:0]     walk_tree_wdata;
    logic              tree_we;
    logic [AW-1:0]     tree_waddr;
    logic [TW-1:0]     tree_wdata;

    logic              lp_we;
    logic [VW-1:0]     lp_waddr;
    logic [TW-1:0]     lp_wdata;
    logic [TW-1:0]     lp_rdata;

    dcrq_walk #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (walk_ctl),
        .at         (walk_at),
        .busy       (walk_busy),
        .acc        (walk_acc),
        .tree_raddr (tree_raddr),
        .tree_rdata (tree_rdata),
        .tree_we    (walk_tree_we),
        .tree_waddr (walk_tree_waddr),
        .tree_wdata (walk_tree_wdata)
    );

    // fenwick tree, entry of position p at address p-1
    dcrq_ram #(
        .DEPTH (MAX_LENGTH),
        .WIDTH (TW)
    ) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    // last position of each value, zero means never seen
    dcrq_ram #(
        .DEPTH (VALUE_COUNT),
        .WIDTH (TW)
    ) u_lp_ram (
        .clk   (clk),
        .we    (lp_we),
        .waddr (lp_waddr),
        .wdata (lp_wdata),
        .raddr (vidx),
        .rdata (lp_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_req == REQ_APPEND)
                    begin
                        if (is_full)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = REDUCE ? S_MOD : S_LP_RD;
                        end
                    end
                    else if (bad_left)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_Q1_WAIT;
                    end
                end
            end
            S_MOD:
            begin
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = S_LP_RD;
                end
            end
            S_LP_RD:
            begin
                state_next = S_LP_CHK;
            end
            S_LP_CHK:
            begin
                state_next = (lp_rdata != '0) ? S_RM_WAIT : S_ADD_WAIT;
            end
            S_RM_WAIT:
            begin
                if (!walk_busy)
                begin
                    state_next = S_ADD_WAIT;
                end
            end
            S_ADD_WAIT:
            begin
                if (!walk_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_Q1_WAIT:
            begin
                if (!walk_busy)
                begin
                    state_next = S_Q2_WAIT;
                end
            end
            S_Q2_WAIT:
            begin
                if (!walk_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // sequencer outputs: walk commands and table writes
    always_comb
    begin
        s_tready   = 1'b0;
        walk_ctl   = '0;
        walk_at    = '0;
        lp_we      = 1'b0;
        lp_waddr   = vidx;
        lp_wdata   = pos;
        tree_we    = walk_tree_we;
        tree_waddr = walk_tree_waddr;
        tree_wdata = walk_tree_wdata;

        case (state_reg)
            S_CLEAR:
            begin
                tree_we    = clr_tree_en;
                tree_waddr = AW'(clr_cnt_reg);
                tree_wdata = '0;
                lp_we      = clr_lp_en;
                lp_waddr   = VW'(clr_cnt_reg);
                lp_wdata   = '0;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                // first prefix walk starts with the request itself
                if (s_tvalid && (in_req == REQ_QUERY) && !bad_left)
                begin
                    walk_ctl.start     = 1'b1;
                    walk_ctl.clear_acc = 1'b1;
                    walk_at            = IW'(len_reg);
                end
            end
            S_LP_CHK:
            begin
                // record the new last position and start the walk: remove the old mark if any, else add the new one
                lp_we             = 1'b1;
                walk_ctl.start    = 1'b1;
                walk_ctl.add_mode = 1'b1;
                if (lp_rdata != '0)
                begin
                    walk_ctl.negate = 1'b1;
                    walk_at         = IW'(lp_rdata);
                end
                else
                begin
                    walk_at = IW'(pos);
                end
            end
            S_RM_WAIT:
            begin
                if (!walk_busy)
                begin
                    walk_ctl.start    = 1'b1;
                    walk_ctl.add_mode = 1'b1;
                    walk_at           = IW'(pos);
                end
            end
            S_Q1_WAIT:
            begin
                // subtract prefix(left-1)
                if (!walk_busy)
                begin
                    walk_ctl.start  = 1'b1;
                    walk_ctl.negate = 1'b1;
                    walk_at         = IW'(left_m1);
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        len_next     = len_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        left_next    = left_reg;
        res_cnt_next = res_cnt_reg;
        res_st_next  = res_st_reg;
        out_cnt_next = out_cnt_reg;
        out_st_next  = out_st_reg;
        ov_next      = ov_reg;

        if (m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next     = in_value;
                    left_next    = in_left;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    res_cnt_next = '0;
                    res_st_next  = ST_OK;
                    if ((in_req == REQ_APPEND) && is_full)
                    begin
                        res_st_next = ST_FULL;
                    end
                    else if ((in_req == REQ_QUERY) && bad_left)
                    begin
                        res_st_next = ST_BAD_LEFT;
                    end
                end
            end
            S_MOD:
            begin
                // the quotient first, then value minus quotient times count
                if (bit_cnt_reg == '0)
                begin
                    rem_next = mod_quot;
                end
                else
                begin
                    rem_next = mod_rem;
                end
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            S_ADD_WAIT:
            begin
                if (!walk_busy)
                begin
                    len_next = pos;
                end
            end
            S_Q2_WAIT:
            begin
                if (!walk_busy)
                begin
                    res_cnt_next = walk_acc;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next      = 1'b1;
                    out_cnt_next = res_cnt_reg;
                    out_st_next  = res_st_reg;
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            len_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            len_reg     <= len_next;
            ov_reg      <= ov_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        left_reg    <= left_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
        out_cnt_reg <= out_cnt_next;
        out_st_reg  <= out_st_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_st_reg, out_cnt_reg};

    // checks
    `ASSERT_CLK(a_walk_start_free, clk, rst_n, walk_ctl.start |-> !walk_busy, "walk started while busy")
    `ASSERT_CLK(a_ready_walk_idle, clk, rst_n, s_tready |-> !walk_busy, "ready while a walk runs")
    `ASSERT_CLK(a_tree_wr_in_append, clk, rst_n, walk_tree_we |-> (state_reg == S_RM_WAIT || state_reg == S_ADD_WAIT), "tree written outside an append")
    `ASSERT_CLK(a_len_step, clk, rst_n, (len_reg != $past(len_reg)) |-> (len_reg == $past(len_reg) + 1'b1), "length moved by more than one")
    `ASSERT_NEVER(a_len_bound, clk, rst_n, len_reg > TW'(MAX_LENGTH), "length beyond the store size")

endmodule

`default_nettype wire

### test/dcrq_checker.sv
// ----------------------------------------------------------------------------
// dcrq_checker
// tracks requests and results of the distinct count block, keeps its own
// copy of the position table and the fenwick tree, and compares each result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dcrq_checker
    import dcrq_pkg::*;
#(
    parameter int MAX_LENGTH  = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // value [9:0], left [20:10], zero pad
    input  logic                   s_tuser,   // req_type: 0 append, 1 query
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // distinct_count [10:0], status [12:11], pad
    output logic [31:0]            pending,
    output logic [31:0]            errors
);

    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        status_t          status;
    } outcome_t;

    // last position of each value, 0 when never seen
    int seen_at [0:VALUE_COUNT-1];
    // one mark per value at its latest position
    int mark_tree [1:MAX_LENGTH];
    int stored_len;

    outcome_t due_results [$];

    initial errors = '0;

    task automatic report_mismatch(input string what, input int got, input int want_val);
        if (errors < MAX_PRINTED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want_val);
        errors = errors + 1;
    endtask

    function automatic int lowest_set(input int x);
        return x & (-x);
    endfunction

    function automatic void move_mark(input int at, input int delta);
        while (at >= 1 && at <= MAX_LENGTH) begin
            mark_tree[at] += delta;
            at += lowest_set(at);
        end
    endfunction

    function automatic int marks_upto(input int at);
        int sum;
        sum = 0;
        if (at > MAX_LENGTH)
            at = MAX_LENGTH;
        while (at != 0) begin
            sum += mark_tree[at];
            at -= lowest_set(at);
        end
        return sum;
    endfunction

    function automatic outcome_t apply_request(input logic kind,
                                               input logic [VAL_W-1:0] val,
                                               input logic [LEFT_W-1:0] lb);
        outcome_t res;
        int slot;
        int diff;
        res.count  = '0;
        res.status = ST_OK;
        slot = int'(val) % VALUE_COUNT;
        if (kind == REQ_APPEND) begin
            if (stored_len >= MAX_LENGTH) begin
                res.status = ST_FULL;
            end
            else begin
                stored_len++;
                // drop the older mark of this value before marking the new spot
                if (seen_at[slot] != 0)
                    move_mark(seen_at[slot], -1);
                seen_at[slot] = stored_len;
                move_mark(stored_len, 1);
            end
        end
        else if (lb == 0 || int'(lb) > stored_len) begin
            res.status = ST_BAD_LEFT;
        end
        else begin
            diff = marks_upto(stored_len) - marks_upto(int'(lb) - 1);
            res.count = diff[CNT_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t want;
        logic [CNT_W-1:0] got_count;
        status_t got_status;
        if (!rst_n) begin
            for (int i = 0; i < VALUE_COUNT; i++)
                seen_at[i] = 0;
            for (int i = 1; i <= MAX_LENGTH; i++)
                mark_tree[i] = 0;
            stored_len = 0;
            due_results.delete();
            pending <= '0;
        end
        else begin
            if (s_tvalid && s_tready)
                due_results.push_back(apply_request(s_tuser, s_tdata[VAL_W-1:0],
                                                    s_tdata[VAL_W +: LEFT_W]));
            if (m_tvalid && m_tready) begin
                got_count  = m_tdata[CNT_W-1:0];
                got_status = status_t'(m_tdata[CNT_W +: STAT_W]);
                if (due_results.size() == 0) begin
                    report_mismatch("result with no request pending", int'(got_count), -1);
                end
                else begin
                    want = due_results.pop_front();
                    if (got_count != want.count)
                        report_mismatch("distinct_count", int'(got_count), int'(want.count));
                    if (got_status != want.status)
                        report_mismatch("status", int'(got_status), int'(want.status));
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives append and query requests into the distinct count block with bursty
// input and a stalling output, a checker beside the block predicts each result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import dcrq_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int VALUE_RANGE  = 1024;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1930;
    // one full hold-off of the sink plus the clearing pass fit well inside this
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 600;
    // this covers a late stray result after the last drain
    localparam int TAIL_CYCLES  = 64;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // value [9:0], left [20:10], zero pad
    logic                   s_tuser  = 1'b0; // req_type: 0 append, 1 query
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // distinct_count [10:0], status [12:11], pad

    logic [31:0] pending;
    logic [31:0] errors;

    // stimulus-side view of the store fill, used only to aim the left bounds
    int fill_level  = 0;
    int burst_left  = 1;
    int results_seen = 0;
    int stall_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    distinct_count_range_query #(
        .MAX_LENGTH  (STORE_DEPTH),
        .VALUE_COUNT (VALUE_RANGE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dcrq_checker #(
        .MAX_LENGTH  (STORE_DEPTH),
        .VALUE_COUNT (VALUE_RANGE)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .errors   (errors)
    );

    // offer one request and hold it until the block takes it; at the end of a
    // burst draw a new burst length and maybe drop valid for a random gap
    task automatic issue(input logic kind, input logic [VAL_W-1:0] val,
                         input logic [LEFT_W-1:0] lb);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{IN_PAD_W{1'b0}}, lb, val};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == REQ_APPEND && fill_level < STORE_DEPTH)
            fill_level++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // about a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop offering and wait until every result in flight has come back
    task automatic drain_results;
        if (s_tvalid)
            s_tvalid <= 1'b0;
        // let the checker book the last accepted request first
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // count results taken by the sink, the stall pattern keys on it
    always @(posedge clk)
        if (m_tvalid && m_tready)
            results_seen <= results_seen + 1;

    // result sink: stalls in stretches of changing style, with one long hold-off
    // partway through while the source keeps pushing so the block backs up
    initial begin : result_sink
        int mode;
        int span;
        int tick;
        logic held_off;
        tick = 0;
        held_off = 1'b0;
        wait (rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge clk);
                tick++;
                if (!held_off && results_seen >= HOLD_AFTER) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    held_off = 1'b1;
                end
                else begin
                    case (mode)
                        0:       m_tready <= 1'b1;                          // no stalls
                        1:       m_tready <= 1'($urandom_range(0, 1));      // coin flip
                        2:       m_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                        default: m_tready <= (tick % 4 != 0);               // fixed rhythm
                    endcase
                end
            end
        end
    end

    // watchdog: too long with nothing accepted on either side ends the run
    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int pick;
        logic kind;
        logic [VAL_W-1:0] val;
        logic [LEFT_W-1:0] lb;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // the block clears its tables first; issue waits on tready through that

        // queries on an empty store are all out of range
        issue(REQ_QUERY, 10'h000, 11'd1);
        issue(REQ_QUERY, 10'h3FF, 11'd0);
        issue(REQ_QUERY, 10'h155, 11'h7FF);
        // appends with extreme values, then a repeat that moves a mark
        issue(REQ_APPEND, 10'h000, 11'h7FF);
        issue(REQ_APPEND, 10'h3FF, 11'd0);
        issue(REQ_APPEND, 10'h000, 11'h2AA);
        // store holds 0, 1023, 0
        issue(REQ_QUERY, 10'h2AA, 11'd1);
        issue(REQ_QUERY, 10'h000, 11'd3);
        issue(REQ_QUERY, 10'h3FF, 11'd4);   // one past the end
        issue(REQ_QUERY, 10'h000, 11'd2);
        issue(REQ_APPEND, 10'h3FF, 11'h555);
        issue(REQ_APPEND, 10'h2AA, 11'd1);
        issue(REQ_APPEND, 10'h155, 11'd2);
        issue(REQ_APPEND, 10'h2AA, 11'd3);
        // store holds 0, 1023, 0, 1023, 682, 341, 682
        issue(REQ_QUERY, 10'h000, 11'd1);
        issue(REQ_QUERY, 10'h000, 11'd7);
        issue(REQ_QUERY, 10'h000, 11'd5);
        issue(REQ_QUERY, 10'h000, 11'd0);
        issue(REQ_QUERY, 10'h000, 11'd1024);
        issue(REQ_QUERY, 10'h000, 11'h7FF);
        // pause until the block has answered everything so far
        drain_results();

        // random part: appends win so the store fills and later appends are refused
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            kind = ($urandom_range(0, 99) < 62) ? REQ_APPEND : REQ_QUERY;
            val  = VAL_W'($urandom);
            lb   = LEFT_W'($urandom);
            if (kind == REQ_APPEND) begin
                // half of the values from a narrow set so repeats are common
                if ($urandom_range(0, 1) == 0)
                    val = VAL_W'($urandom_range(0, 15));
            end
            else begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       lb = 11'd1;
                    1:       lb = LEFT_W'(fill_level);
                    2:       lb = LEFT_W'(fill_level + 1);
                    3:       lb = LEFT_W'($urandom_range(0, 2047));
                    4:       lb = 11'd0;
                    default: lb = LEFT_W'($urandom_range(1, (fill_level == 0) ? 1 : fill_level));
                endcase
            end
            issue(kind, val, lb);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/dcrq_pkg.sv
design/dcrq_ram.sv
design/dcrq_walk.sv
design/distinct_count_range_query.sv
test/dcrq_checker.sv
test/tb.sv
